// ===== rtl/ght_pkg.sv =====
// package: types and constants of the generational handle table
package ght_pkg;

    localparam int unsigned PTR_W = 64;
    localparam int unsigned GEN_W = 32;
    localparam int unsigned TYPE_W = 16;
    localparam logic [GEN_W-1:0] GEN_RESET = 32'h7000_0000;
    localparam logic [63:0] COOKIE_RESET = 64'd1;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_RESOLVE  = 2'd1;
    localparam logic [1:0] OP_RELEASE  = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] pointer;
        logic [63:0] obj_size;
        logic [15:0] obj_type;
        logic [31:0] entry_flags;
        logic [31:0] tag_hash;
        logic [63:0] token_in;
    } ght_in_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] token_out;
        logic [63:0] pointer_out;
        logic [63:0] size_out;
        logic [31:0] flags_out;
        logic [31:0] tag_hash_out;
    } ght_out_t;

    // one stored entry, valid bit kept apart
    typedef struct packed {
        logic [63:0] mptr;
        logic [63:0] size;
        logic [31:0] flags;
        logic [31:0] tag;
        logic [15:0] etype;
        logic [31:0] gen;
    } ght_entry_t;

    function automatic logic [63:0] rotl11(input logic [63:0] v);
        return {v[52:0], v[63:53]};
    endfunction

    function automatic logic [63:0] rotl29(input logic [63:0] v);
        return {v[34:0], v[63:35]};
    endfunction

    function automatic logic [63:0] mask_ptr(input logic [63:0] p, input logic [63:0] sz,
                                             input logic [31:0] g, input logic [63:0] ck);
        return p ^ ck ^ rotl11(sz) ^ {25'd0, g, 7'd0};
    endfunction

endpackage

// ===== rtl/ght_mem.sv =====
// module: entry memory with one write port and one registered read port
module ght_mem #(
    parameter int unsigned ENTRIES = 256,
    parameter int unsigned AW = 8
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  ght_pkg::ght_entry_t wdata,
    input  logic [AW-1:0]       raddr,
    output ght_pkg::ght_entry_t rdata
);
    import ght_pkg::*;

    ght_entry_t mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/generational_handle_table_unit.sv =====
// top level: generational handle table with sequencer and entry memory
//
//  channel | ports          | direction | content
//  --------+----------------+-----------+---------------------------
//  input   | s_valid/s_ready| in        | one ght_in_t item
//  result  | m_valid/m_ready| out       | one ght_out_t item
//  config  | cfg_valid/ready| in        | 64-bit cookie
//
// register scans the table, reading one entry per cycle through the single
// read port of the entry memory, and stops early on a match. valid bits
// live in flip-flops, so clear and reset are immediate with no memory sweep.
// a held result blocks the next item only until it is taken; s_ready is
// high while the sequencer is idle and no result is held.
module generational_handle_table_unit #(
    parameter int unsigned ENTRIES = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ght_pkg::ght_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ght_pkg::ght_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [63:0]       cfg_data
);
    import ght_pkg::*;

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_LOOK = 5'b00100,
        ST_CHK  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    ght_in_t     req_reg;
    logic [63:0] cookie_reg;
    logic [31:0] gcnt_reg, gcnt_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0] idx_reg, idx_next;       // address of the entry being read
    logic [CW-1:0] chk_reg, chk_next;       // address of entry whose data arrives
    logic          have_free_reg, have_free_next;
    logic [AW-1:0] free_reg, free_next;
    ght_out_t    res_reg, res_next;
    logic        mvalid_reg, mvalid_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    ght_entry_t    wdata, rdata;

    ght_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // token decode for resolve and release
    logic [63:0] raw_tok;
    logic [15:0] tok_slot1;
    logic        tok_ok;
    assign raw_tok   = req_reg.token_in ^ rotl29(cookie_reg);
    assign tok_slot1 = raw_tok[15:0];
    assign tok_ok    = (req_reg.token_in != 64'd0) && (tok_slot1 != 16'd0)
                    && ({16'd0, tok_slot1} <= 32'(ENTRIES));

    logic [AW-1:0] tok_idx;
    assign tok_idx = AW'(tok_slot1 - 16'd1);

    // slot of the offered item, so its read is issued at the accepting edge
    logic [63:0]   s_raw_tok;
    logic [AW-1:0] s_tok_idx;
    assign s_raw_tok = s_data.token_in ^ rotl29(cookie_reg);
    assign s_tok_idx = AW'(s_raw_tok[15:0] - 16'd1);

    logic [63:0] dec_ptr;
    assign dec_ptr = mask_ptr(rdata.mptr, rdata.size, rdata.gen, cookie_reg);

    logic [AW-1:0] chk_a;
    assign chk_a = chk_reg[AW-1:0];

    logic [31:0] gen_inc, gen_new;
    assign gen_inc = gcnt_reg + 32'd1;
    assign gen_new = (gen_inc == 32'd0) ? 32'd1 : gen_inc;

    assign s_ready   = (state_reg == ST_IDLE) && !mvalid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = mvalid_reg;
    assign m_data    = res_reg;
    assign raddr     = (state_reg == ST_IDLE) ? s_tok_idx : idx_reg[AW-1:0];

    always_comb begin
        state_next     = state_reg;
        gcnt_next      = gcnt_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        chk_next       = chk_reg;
        have_free_next = have_free_reg;
        free_next      = free_reg;
        res_next       = res_reg;
        mvalid_next    = mvalid_reg;
        we             = 1'b0;
        waddr          = chk_a;
        wdata          = rdata;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    res_next = '0;
                    idx_next = '0;
                    have_free_next = 1'b0;
                    case (s_data.op)
                        OP_REGISTER: begin
                            if (s_data.pointer == 64'd0) begin
                                mvalid_next = 1'b1;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            valid_next   = '0;
                            gcnt_next    = gen_inc;
                            res_next.ok  = 1'b1;
                            mvalid_next  = 1'b1;
                        end
                        default: state_next = ST_LOOK;
                    endcase
                end
            end
            ST_LOOK: begin
                // read of the token's slot was issued before; data valid now
                state_next  = ST_IDLE;
                mvalid_next = 1'b1;
                if (tok_ok && valid_reg[tok_idx] && rdata.etype == raw_tok[31:16]
                    && rdata.gen == raw_tok[63:32]) begin
                    if (req_reg.op == OP_RELEASE) begin
                        valid_next[tok_idx] = 1'b0;
                        res_next.ok = 1'b1;
                    end else if (raw_tok[31:16] == req_reg.obj_type && dec_ptr != 64'd0) begin
                        res_next.ok           = 1'b1;
                        res_next.pointer_out  = dec_ptr;
                        res_next.size_out     = rdata.size;
                        res_next.flags_out    = rdata.flags;
                        res_next.tag_hash_out = rdata.tag;
                    end
                end
            end
            ST_SCAN: begin
                // issue read of entry idx, then examine it in ST_CHK
                chk_next   = idx_reg;
                idx_next   = idx_reg + CW'(1);
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (chk_reg == CW'(ENTRIES)) begin
                    // scan done, no match
                    state_next  = ST_IDLE;
                    mvalid_next = 1'b1;
                    if (have_free_reg) begin
                        gcnt_next  = gen_new;
                        we         = 1'b1;
                        waddr      = free_reg;
                        wdata.etype = req_reg.obj_type;
                        wdata.gen   = gen_new;
                        wdata.size  = req_reg.obj_size;
                        wdata.flags = req_reg.entry_flags;
                        wdata.tag   = req_reg.tag_hash;
                        wdata.mptr  = mask_ptr(req_reg.pointer, req_reg.obj_size, gen_new,
                                               cookie_reg);
                        valid_next[free_reg] = 1'b1;
                        res_next.ok = 1'b1;
                        res_next.token_out = {gen_new, req_reg.obj_type,
                                              16'(free_reg) + 16'd1} ^ rotl29(cookie_reg);
                    end
                end else if (!valid_reg[chk_a]) begin
                    if (!have_free_reg) begin
                        have_free_next = 1'b1;
                        free_next      = chk_a;
                    end
                    chk_next = idx_reg;
                    idx_next = (idx_reg == CW'(ENTRIES)) ? idx_reg : idx_reg + CW'(1);
                end else if (rdata.etype == req_reg.obj_type && dec_ptr == req_reg.pointer) begin
                    state_next  = ST_IDLE;
                    mvalid_next = 1'b1;
                    we          = 1'b1;
                    wdata.size  = req_reg.obj_size;
                    wdata.flags = req_reg.entry_flags;
                    wdata.tag   = req_reg.tag_hash;
                    wdata.mptr  = mask_ptr(req_reg.pointer, req_reg.obj_size, rdata.gen,
                                           cookie_reg);
                    res_next.ok = 1'b1;
                    res_next.token_out = {rdata.gen, req_reg.obj_type,
                                          16'(chk_a) + 16'd1} ^ rotl29(cookie_reg);
                end else begin
                    chk_next = idx_reg;
                    idx_next = (idx_reg == CW'(ENTRIES)) ? idx_reg : idx_reg + CW'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // the scan ends when chk reaches ENTRIES, past the last address; idx saturates at ENTRIES
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gcnt_reg      <= GEN_RESET;
            cookie_reg    <= COOKIE_RESET;
            valid_reg     <= '0;
            mvalid_reg    <= 1'b0;
            idx_reg       <= '0;
            chk_reg       <= '0;
            have_free_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            gcnt_reg      <= gcnt_next;
            valid_reg     <= valid_next;
            mvalid_reg    <= mvalid_next;
            idx_reg       <= idx_next;
            chk_reg       <= chk_next;
            have_free_reg <= have_free_next;
            if (cfg_valid && cfg_ready) begin
                cookie_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        free_reg <= free_next;
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end
endmodule

// ===== rtl/ght_checker.sv =====
// checker: port-level assertions for the handle table, with its bind
module ght_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input ght_pkg::ght_out_t m_data
);
    import ght_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_no_accept_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a result waits");

    a_accept_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accept");

    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.ok |-> m_data.token_out == 64'd0 && m_data.pointer_out == 64'd0)
        else $error("failed result carries data");
endmodule

bind generational_handle_table_unit ght_checker u_ght_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// ===== dv/testbench.sv =====
// testbench: self-checking run of the generational handle table against its own predictor
`timescale 1ns / 100ps

module testbench;
    import ght_pkg::*;

    localparam int unsigned NSLOT = 256;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned SETTLE = 300;

    typedef struct {
        logic [63:0] tok;
        logic [15:0] typ;
    } token_ref_t;

    typedef struct {
        logic [63:0] ptr;
        logic [15:0] typ;
    } object_ref_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    ght_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    ght_out_t    m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;

    generational_handle_table_unit #(.ENTRIES(NSLOT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // shadow copy of the table
    logic        shadow_live [NSLOT];
    logic [63:0] shadow_mptr [NSLOT];
    logic [63:0] shadow_size [NSLOT];
    logic [31:0] shadow_flags [NSLOT];
    logic [31:0] shadow_tag [NSLOT];
    logic [15:0] shadow_type [NSLOT];
    logic [31:0] shadow_gen [NSLOT];
    logic [31:0] shadow_gen_ctr;
    logic [63:0] shadow_cookie;

    ght_in_t     pending_ops [$];
    ght_out_t    awaited_results [$];
    token_ref_t  token_pool [$];
    object_ref_t object_pool [$];

    int unsigned error_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;
    bit          hold_request = 0;
    int unsigned hold_left = 0;
    bit          item_taken = 0;
    int unsigned quiet_cycles = 0;

    // clock, 2 ns period
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] rot_left11(logic [63:0] v);
        return {v[52:0], v[63:53]};
    endfunction

    function automatic logic [63:0] rot_left29(logic [63:0] v);
        return {v[34:0], v[63:35]};
    endfunction

    // pointer masking is its own inverse for fixed size, generation and cookie
    function automatic logic [63:0] scramble_ptr(logic [63:0] p, logic [63:0] sz,
                                                 logic [31:0] g);
        return p ^ shadow_cookie ^ rot_left11(sz) ^ ({32'd0, g} << 7);
    endfunction

    function automatic logic [63:0] encode_token(logic [15:0] slot1, logic [15:0] typ,
                                                 logic [31:0] g);
        return {g, typ, slot1} ^ rot_left29(shadow_cookie);
    endfunction

    function automatic void wipe_slot(int unsigned i);
        shadow_live[i] = 1'b0;
        shadow_mptr[i] = '0;
        shadow_size[i] = '0;
        shadow_flags[i] = '0;
        shadow_tag[i] = '0;
        shadow_type[i] = '0;
        shadow_gen[i] = '0;
    endfunction

    function automatic void remember_token(logic [63:0] tok, logic [15:0] typ,
                                           logic [63:0] ptr);
        token_ref_t t;
        object_ref_t o;
        t.tok = tok;
        t.typ = typ;
        o.ptr = ptr;
        o.typ = typ;
        token_pool.push_back(t);
        object_pool.push_back(o);
        if (token_pool.size() > 32) token_pool.delete($urandom_range(31));
        if (object_pool.size() > 32) object_pool.delete($urandom_range(31));
    endfunction

    // token lookup: slot index when the token names a live entry, else -1
    function automatic int lookup_token(logic [63:0] tok, output logic [15:0] ttype);
        logic [63:0] raw;
        int unsigned s;
        raw = tok ^ rot_left29(shadow_cookie);
        ttype = raw[31:16];
        s = raw[15:0];
        if (tok == '0 || s == 0 || s > NSLOT) return -1;
        if (shadow_live[s-1] && shadow_type[s-1] == ttype && shadow_gen[s-1] == raw[63:32])
            return s - 1;
        return -1;
    endfunction

    // apply one item to the shadow table and return the result it should produce
    function automatic ght_out_t table_step(ght_in_t it);
        ght_out_t r;
        int free_slot;
        int hit;
        logic [15:0] ttype;
        logic [63:0] p;
        r = '0;
        case (it.op)
            OP_REGISTER: begin
                if (it.pointer == '0) return r;
                free_slot = -1;
                for (int i = 0; i < NSLOT; i++) begin
                    if (!shadow_live[i]) begin
                        if (free_slot < 0) free_slot = i;
                    end else if (shadow_type[i] == it.obj_type &&
                                 scramble_ptr(shadow_mptr[i], shadow_size[i], shadow_gen[i])
                                 == it.pointer) begin
                        // same object seen again: refresh in place
                        shadow_mptr[i] = scramble_ptr(it.pointer, it.obj_size, shadow_gen[i]);
                        shadow_size[i] = it.obj_size;
                        shadow_flags[i] = it.entry_flags;
                        shadow_tag[i] = it.tag_hash;
                        r.ok = 1'b1;
                        r.token_out = encode_token(i + 1, it.obj_type, shadow_gen[i]);
                        remember_token(r.token_out, it.obj_type, it.pointer);
                        return r;
                    end
                end
                if (free_slot < 0) return r;
                shadow_gen_ctr++;
                if (shadow_gen_ctr == '0) shadow_gen_ctr++;
                shadow_live[free_slot] = 1'b1;
                shadow_size[free_slot] = it.obj_size;
                shadow_flags[free_slot] = it.entry_flags;
                shadow_tag[free_slot] = it.tag_hash;
                shadow_type[free_slot] = it.obj_type;
                shadow_gen[free_slot] = shadow_gen_ctr;
                shadow_mptr[free_slot] = scramble_ptr(it.pointer, it.obj_size, shadow_gen_ctr);
                r.ok = 1'b1;
                r.token_out = encode_token(free_slot + 1, it.obj_type, shadow_gen_ctr);
                remember_token(r.token_out, it.obj_type, it.pointer);
            end
            OP_RESOLVE: begin
                hit = lookup_token(it.token_in, ttype);
                if (hit < 0 || ttype != it.obj_type) return r;
                p = scramble_ptr(shadow_mptr[hit], shadow_size[hit], shadow_gen[hit]);
                if (p == '0) return r;
                r.ok = 1'b1;
                r.pointer_out = p;
                r.size_out = shadow_size[hit];
                r.flags_out = shadow_flags[hit];
                r.tag_hash_out = shadow_tag[hit];
            end
            OP_RELEASE: begin
                hit = lookup_token(it.token_in, ttype);
                if (hit >= 0) begin
                    wipe_slot(hit);
                    r.ok = 1'b1;
                end
            end
            default: begin
                for (int i = 0; i < NSLOT; i++) wipe_slot(i);
                shadow_gen_ctr++;
                r.ok = 1'b1;
            end
        endcase
        return r;
    endfunction

    // watchdog plus result check and prediction at each rising edge
    always @(posedge aclk) begin
        ght_out_t want;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t unexpected result item %p", $time, m_data);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_data.ok !== want.ok) begin
                    $display("%0t ok exp %0h got %0h", $time, want.ok, m_data.ok);
                    error_count++;
                end
                if (m_data.token_out !== want.token_out) begin
                    $display("%0t token_out exp %h got %h", $time, want.token_out,
                             m_data.token_out);
                    error_count++;
                end
                if (m_data.pointer_out !== want.pointer_out) begin
                    $display("%0t pointer_out exp %h got %h", $time, want.pointer_out,
                             m_data.pointer_out);
                    error_count++;
                end
                if (m_data.size_out !== want.size_out) begin
                    $display("%0t size_out exp %h got %h", $time, want.size_out,
                             m_data.size_out);
                    error_count++;
                end
                if (m_data.flags_out !== want.flags_out) begin
                    $display("%0t flags_out exp %h got %h", $time, want.flags_out,
                             m_data.flags_out);
                    error_count++;
                end
                if (m_data.tag_hash_out !== want.tag_hash_out) begin
                    $display("%0t tag_hash_out exp %h got %h", $time, want.tag_hash_out,
                             m_data.tag_hash_out);
                    error_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            awaited_results.push_back(table_step(s_data));
            item_taken <= 1'b1;
        end
        if (aresetn && cfg_valid && cfg_ready) shadow_cookie = cfg_data;
    end

    // driver: offers the next pending item once the previous one is gone
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            item_taken <= 1'b0;
            if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_ops.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request <= 1'b0;
            hold_left <= 2000;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // keep the pending queue short so tokens in the pool stay fresh
    task automatic queue_item(ght_in_t it);
        while (pending_ops.size() > 3) @(posedge aclk);
        pending_ops.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_valid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_cookie(logic [63:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic ght_in_t noise_item(logic [1:0] op);
        ght_in_t it;
        it.op = op;
        it.pointer = {$urandom, $urandom};
        it.obj_size = {$urandom, $urandom};
        it.obj_type = $urandom;
        it.entry_flags = $urandom;
        it.tag_hash = $urandom;
        it.token_in = {$urandom, $urandom};
        return it;
    endfunction

    // mostly well-formed traffic built on tokens and objects already seen
    task automatic send_random();
        ght_in_t it;
        int unsigned r;
        int unsigned k;
        r = $urandom_range(99);
        if (r < 38) begin
            it = noise_item(OP_REGISTER);
            it.obj_type = ($urandom_range(3) != 0) ? 16'($urandom_range(3)) : it.obj_type;
            if (object_pool.size() != 0 && $urandom_range(99) < 35) begin
                k = $urandom_range(object_pool.size() - 1);
                it.pointer = object_pool[k].ptr;
                it.obj_type = object_pool[k].typ;
            end else if ($urandom_range(49) == 0) begin
                it.pointer = '0;
            end
        end else if (r < 96) begin
            it = noise_item(r < 72 ? OP_RESOLVE : OP_RELEASE);
            k = $urandom_range(99);
            if (token_pool.size() != 0 && k < 85) begin
                k = $urandom_range(token_pool.size() - 1);
                it.token_in = token_pool[k].tok;
                if ($urandom_range(9) != 0) it.obj_type = token_pool[k].typ;
            end else if (k < 90) begin
                it.token_in = '0;
            end
        end else begin
            it = noise_item(OP_CLEAR);
        end
        queue_item(it);
    endtask

    task automatic random_phase(int unsigned count);
        for (int unsigned n = 0; n < count; n++) send_random();
    endtask

    initial begin
        ght_in_t it;
        logic [63:0] ck;
        logic [63:0] tk1;
        logic [63:0] tk2;
        logic [63:0] raw;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < NSLOT; i++) wipe_slot(i);
        shadow_gen_ctr = GEN_RESET;
        shadow_cookie = COOKIE_RESET;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ---- phase 1: sender idles 33%, receiver 59%
        sender_idle_pct = 33;
        receiver_idle_pct = 59;
        ck = 64'h9e37_79b9_7f4a_7c15;
        write_cookie(ck);

        // directed: extremes, every op, the failure paths
        it = noise_item(OP_REGISTER);
        it.pointer = '0;
        queue_item(it);                                   // null pointer fails
        it = '1;
        it.op = OP_REGISTER;
        queue_item(it);                                   // all-ones object, slot 1
        it = '0;
        it.op = OP_REGISTER;
        it.pointer = 64'd1;
        queue_item(it);                                   // minimal object, slot 2
        it = '1;
        it.op = OP_REGISTER;
        it.obj_size = 64'd5;
        it.entry_flags = '0;
        it.tag_hash = 32'h1234_5678;
        queue_item(it);                                   // same object: update in place
        tk1 = {GEN_RESET + 32'd1, 16'hffff, 16'd1} ^ rot_left29(ck);
        tk2 = {GEN_RESET + 32'd2, 16'h0000, 16'd2} ^ rot_left29(ck);
        it = noise_item(OP_RESOLVE);
        it.token_in = tk1;
        it.obj_type = 16'hffff;
        queue_item(it);                                   // good resolve
        it.obj_type = 16'h0000;
        queue_item(it);                                   // type mismatch
        it.token_in = '0;
        queue_item(it);                                   // zero token
        it.token_in = {GEN_RESET + 32'd1, 16'hffff, 16'd0} ^ rot_left29(ck);
        it.obj_type = 16'hffff;
        queue_item(it);                                   // slot zero
        it.token_in = {GEN_RESET + 32'd1, 16'hffff, 16'(NSLOT + 1)} ^ rot_left29(ck);
        queue_item(it);                                   // slot past the end
        it.token_in = {32'hffff_ffff, 16'hffff, 16'hffff} ^ rot_left29(ck);
        queue_item(it);
        it = noise_item(OP_RELEASE);
        it.token_in = tk2;
        queue_item(it);                                   // release slot 2
        queue_item(it);                                   // stale release
        it.op = OP_RESOLVE;
        it.obj_type = 16'h0000;
        queue_item(it);                                   // stale resolve
        it = noise_item(OP_REGISTER);
        it.pointer = 64'd1;
        it.obj_type = 16'h0000;
        queue_item(it);                                   // reuses slot 2, new generation
        it = noise_item(OP_RESOLVE);
        it.token_in = tk2;
        it.obj_type = 16'h0000;
        queue_item(it);                                   // old generation
        it = noise_item(OP_RELEASE);
        it.token_in = '0;
        queue_item(it);
        queue_item(noise_item(OP_CLEAR));
        it = noise_item(OP_RESOLVE);
        it.token_in = tk1;
        it.obj_type = 16'hffff;
        queue_item(it);                                   // gone after clear
        queue_item(noise_item(OP_REGISTER));

        // fill the table to the last slot, then overflow it
        queue_item(noise_item(OP_CLEAR));
        for (int unsigned n = 0; n < NSLOT; n++) queue_item(noise_item(OP_REGISTER));
        queue_item(noise_item(OP_REGISTER));              // full: fails
        queue_item(noise_item(OP_REGISTER));
        wait_drained();
        it = noise_item(OP_REGISTER);
        it.pointer = object_pool[0].ptr;
        it.obj_type = object_pool[0].typ;
        queue_item(it);                                   // match still succeeds when full
        queue_item(noise_item(OP_CLEAR));

        random_phase(150);
        hold_request = 1'b1;                              // long receiver hold-off
        random_phase(200);
        wait_drained();                                   // sender pause until all results in

        write_cookie('1);
        random_phase(60);

        // ---- phase 2: sender idles 59%, receiver 33%
        wait_drained();
        sender_idle_pct = 59;
        receiver_idle_pct = 33;
        write_cookie('0);                                 // zero cookie used as is
        random_phase(170);
        queue_item(noise_item(OP_CLEAR));
        wait_drained();
        // pick the cookie so that the next register encodes to a zero token
        raw = {shadow_gen_ctr + 32'd1, 16'h1234, 16'd1};
        write_cookie({raw[28:0], raw[63:29]});
        it = noise_item(OP_REGISTER);
        it.pointer = it.pointer | 64'd1;
        it.obj_type = 16'h1234;
        queue_item(it);
        random_phase(100);
        wait_drained();
        write_cookie({$urandom, $urandom});
        random_phase(150);

        // ---- phase 3: no idling
        wait_drained();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_cookie(64'h8000_0000_0000_0001);
        random_phase(360);

        wait_drained();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
